@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, field widths and the control store of the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// Field widths of the stream payloads
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int POS_W    = 11;
	localparam int CHAR_W   = 8;
	localparam int ATTR_W   = 8;
	localparam int IDX_W    = 11;
	localparam int S_DATA_W = 24;   // char_code, cell_index, zero fill
	localparam int M_DATA_W = 40;   // col, row, pos, char, attr, scrolled
	localparam int CELL_W   = CHAR_W + ATTR_W;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
	localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'd15;

	// Request kinds carried in tuser
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Microprogram step addresses
	typedef enum logic [2:0] {
		ST_CLEAR   = 3'd0,
		ST_IDLE    = 3'd1,
		ST_EXEC    = 3'd2,
		ST_LOAD    = 3'd3,
		ST_SC_INIT = 3'd4,
		ST_COPY    = 3'd5,
		ST_DRAIN   = 3'd6,
		ST_FILL    = 3'd7
	} step_t;

	// Jump conditions; when false the sequencer goes to the next field
	typedef enum logic [2:0] {
		C_NEVER,
		C_PTR_END,
		C_NO_ACC,
		C_SCROLL,
		C_OUT_BUSY,
		C_ONE_ROW
	} cond_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_ITEM,
		RD_PTR
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_ZERO,
		WR_CHAR,
		WR_SPACE,
		WR_COPY
	} wr_sel_t;

	typedef enum logic [1:0] {
		WA_CURSOR,
		WA_PTR,
		WA_DEST
	} wa_sel_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_INC,
		PTR_SRC,
		PTR_FILL
	} ptr_op_t;

	// One control word of the microprogram
	typedef struct packed {
		logic    in_rdy;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		wa_sel_t wa_sel;
		ptr_op_t ptr_op;
		logic    cur_adv;
		logic    set_scr;
		logic    out_load;
		cond_t   cond;
		step_t   jump;
		step_t   next;
	} ctrl_word_t;

	// Control store
	function automatic ctrl_word_t ucode(input step_t step);
		ctrl_word_t cw;
		cw = '{in_rdy: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE, wa_sel: WA_PTR,
			ptr_op: PTR_HOLD, cur_adv: 1'b0, set_scr: 1'b0, out_load: 1'b0,
			cond: C_NEVER, jump: ST_IDLE, next: ST_IDLE};
		unique case (step)
			ST_CLEAR: begin
				// zero one cell per cycle after reset
				cw.wr_sel = WR_ZERO;
				cw.ptr_op = PTR_INC;
				cw.cond   = C_PTR_END;
				cw.jump   = ST_IDLE;
				cw.next   = ST_CLEAR;
			end
			ST_IDLE: begin
				cw.in_rdy = 1'b1;
				cw.cond   = C_NO_ACC;
				cw.jump   = ST_IDLE;
				cw.next   = ST_EXEC;
			end
			ST_EXEC: begin
				// read the cell for a read request, store and advance for a write
				cw.rd_sel  = RD_ITEM;
				cw.wr_sel  = WR_CHAR;
				cw.wa_sel  = WA_CURSOR;
				cw.cur_adv = 1'b1;
				cw.cond    = C_SCROLL;
				cw.jump    = ST_SC_INIT;
				cw.next    = ST_LOAD;
			end
			ST_LOAD: begin
				cw.out_load = 1'b1;
				cw.cond     = C_OUT_BUSY;
				cw.jump     = ST_LOAD;
				cw.next     = ST_IDLE;
			end
			ST_SC_INIT: begin
				cw.set_scr = 1'b1;
				cw.ptr_op  = PTR_SRC;
				cw.cond    = C_ONE_ROW;
				cw.jump    = ST_DRAIN;
				cw.next    = ST_COPY;
			end
			ST_COPY: begin
				// read at ptr, write the previous read one row up
				cw.rd_sel = RD_PTR;
				cw.wr_sel = WR_COPY;
				cw.wa_sel = WA_DEST;
				cw.ptr_op = PTR_INC;
				cw.cond   = C_PTR_END;
				cw.jump   = ST_DRAIN;
				cw.next   = ST_COPY;
			end
			ST_DRAIN: begin
				cw.wr_sel = WR_COPY;
				cw.wa_sel = WA_DEST;
				cw.ptr_op = PTR_FILL;
				cw.next   = ST_FILL;
			end
			ST_FILL: begin
				cw.wr_sel = WR_SPACE;
				cw.ptr_op = PTR_INC;
				cw.cond   = C_PTR_END;
				cw.jump   = ST_LOAD;
				cw.next   = ST_FILL;
			end
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Teletype-style text console over a COLS x ROWS screen store of cells.
// ----------------------------------------------------------------------------
// Requests pass the accept, execute and load steps of the microprogram in turn.
// A new request is taken only after the previous result is loaded; the load
// step waits while the result stream stalls. A write that scrolls copies one
// cell per cycle through the single read and single write port of the screen RAM.
// Reset: asynchronous, clears the cursor and sets the color to COLOR_RESET, then
// a clearing pass zeroes the screen; no request is accepted during it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration: text_color
	input  wire logic                          cfg_we,
	input  wire logic [tcw_pkg::ATTR_W-1:0]    cfg_wdata,
	// request stream
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [tcw_pkg::S_DATA_W-1:0]  s_axis_tdata,  // char_code[7:0], cell_index[18:8]
	input  wire logic                          s_axis_tuser,  // req_type
	// result stream
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// cursor_col[6:0], cursor_row[11:7], cursor_pos[22:12], read_char[30:23],
	// read_attr[38:31], scrolled[39]
	output logic      [tcw_pkg::M_DATA_W-1:0]  m_axis_tdata
);

	import tcw_pkg::*;

	localparam int CELLS = COLS * ROWS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int PW    = $clog2(CELLS + 1);
	localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

	// sequencer
	step_t      step_q;
	ctrl_word_t cw;
	logic       take;

	// datapath registers
	logic [PW-1:0]     ptr_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [ATTR_W-1:0] color_q;
	logic              req_q;
	logic [CHAR_W-1:0] char_q;
	logic [IDX_W-1:0]  idx_q;
	logic              scr_q;
	logic              copy_v_q;
	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	// combinational datapath
	logic              in_fire;
	logic              out_free;
	logic              is_nl;
	logic              wrap;
	logic              last_row;
	logic              scroll;
	logic              ptr_end;
	logic              rd_ok;
	logic [AW-1:0]     cur_addr;
	logic [PW-1:0]     dest_ptr;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	assign cw            = ucode(step_q);
	assign s_axis_tready = cw.in_rdy;
	assign in_fire       = s_axis_tvalid && cw.in_rdy;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// cursor arithmetic
	assign is_nl    = (char_q == NEWLINE_CODE);
	assign wrap     = is_nl || (col_q == CW'(COLS - 1));
	assign last_row = (row_q == RW'(ROWS - 1));
	assign scroll   = (req_q == REQ_WRITE) && wrap && last_row;
	assign cur_addr = AW'(int'(row_q) * COLS + int'(col_q));
	assign ptr_end  = (ptr_q == PW'(CELLS - 1));
	assign dest_ptr = ptr_q - PW'(COLS + 1);
	assign rd_ok    = (req_q == REQ_READ) && (int'(idx_q) < CELLS);

	// jump condition select
	always_comb begin
		take = 1'b0;
		unique case (cw.cond)
			C_NEVER:    take = 1'b0;
			C_PTR_END:  take = ptr_end;
			C_NO_ACC:   take = !in_fire;
			C_SCROLL:   take = scroll;
			C_OUT_BUSY: take = !out_free;
			C_ONE_ROW:  take = (ROWS == 1);
			default:    take = 1'b0;
		endcase
	end

	// RAM read port
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = AW'(ptr_q);
		unique case (cw.rd_sel)
			RD_NONE: ram_re = 1'b0;
			RD_ITEM: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(idx_q);
			end
			RD_PTR:  ram_re = 1'b1;
			default: ram_re = 1'b0;
		endcase
	end

	// RAM write port
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = '0;
		unique case (cw.wr_sel)
			WR_NONE: ram_we = 1'b0;
			WR_ZERO: ram_we = 1'b1;
			WR_CHAR: begin
				ram_we    = (req_q == REQ_WRITE) && !is_nl;
				ram_wdata = {color_q, char_q};
			end
			WR_SPACE: begin
				ram_we    = 1'b1;
				ram_wdata = {color_q, SPACE_CODE};
			end
			WR_COPY: begin
				ram_we    = copy_v_q;
				ram_wdata = ram_rdata;
			end
			default: ram_we = 1'b0;
		endcase
		unique case (cw.wa_sel)
			WA_CURSOR: ram_waddr = cur_addr;
			WA_PTR:    ram_waddr = AW'(ptr_q);
			WA_DEST:   ram_waddr = AW'(dest_ptr);
			default:   ram_waddr = AW'(ptr_q);
		endcase
	end

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// step counter, pointer, cursor and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_CLEAR;
			ptr_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			color_q     <= COLOR_RESET;
			scr_q       <= 1'b0;
			copy_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q   <= take ? cw.jump : cw.next;
			copy_v_q <= (cw.rd_sel == RD_PTR);

			if (cfg_we) begin
				color_q <= cfg_wdata;
			end

			unique case (cw.ptr_op)
				PTR_HOLD: ptr_q <= ptr_q;
				PTR_INC:  ptr_q <= ptr_q + PW'(1);
				PTR_SRC:  ptr_q <= PW'(COLS);
				PTR_FILL: ptr_q <= PW'(CELLS - COLS);
				default:  ptr_q <= ptr_q;
			endcase

			// cursor advance on a write request
			if (cw.cur_adv && (req_q == REQ_WRITE)) begin
				if (wrap) begin
					col_q <= '0;
					if (!last_row) begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end

			if (in_fire) begin
				scr_q <= 1'b0;
			end else if (cw.set_scr) begin
				scr_q <= 1'b1;
			end

			if (cw.out_load && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			req_q  <= s_axis_tuser;
			char_q <= s_axis_tdata[CHAR_W-1:0];
			idx_q  <= s_axis_tdata[CHAR_W +: IDX_W];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cw.out_load && out_free) begin
			out_data_q <= {
				scr_q,
				rd_ok ? ram_rdata[CELL_W-1:CHAR_W] : ATTR_W'(0),
				rd_ok ? ram_rdata[CHAR_W-1:0]      : CHAR_W'(0),
				POS_W'(cur_addr),
				ROW_W'(row_q),
				COL_W'(col_q)
			};
		end
	end

endmodule

`default_nettype wire

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_checker #(
	parameter int COLS = 80,
	parameter int ROWS = 25
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [tcw_pkg::M_DATA_W-1:0]  m_axis_tdata
);

	import tcw_pkg::*;

	logic [COL_W-1:0]  col;
	logic [ROW_W-1:0]  row;
	logic [POS_W-1:0]  pos;
	logic [CHAR_W-1:0] rchar;
	logic [ATTR_W-1:0] rattr;
	logic              scr;
	logic              out_fire;

	assign col      = m_axis_tdata[6:0];
	assign row      = m_axis_tdata[11:7];
	assign pos      = m_axis_tdata[22:12];
	assign rchar    = m_axis_tdata[30:23];
	assign rattr    = m_axis_tdata[38:31];
	assign scr      = m_axis_tdata[39];
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a request is never taken in two consecutive cycles
	a_in_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted back to back");

	// cursor column stays on screen and the fields agree with the linear position
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (int'(col) < COLS) &&
			(pos == POS_W'(int'(row) * COLS + int'(col))))
		else $error("cursor fields inconsistent");

	// a scroll leaves the cursor at the start of the bottom row, no read data
	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && scr |-> (col == '0) && (row == ROW_W'(ROWS - 1)) &&
			(rchar == '0) && (rattr == '0))
		else $error("scroll result malformed");

endmodule

bind text_console_writer tcw_checker #(
	.COLS (COLS),
	.ROWS (ROWS)
) u_tcw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. It sends character writes,
// newlines and cell reads, keeps a shadow screen, cursor and text color, and
// checks every result field against the shadow. Flow control on both streams
// is randomized, with one long result stall that backs up the request side.
// ----------------------------------------------------------------------------

module tb_top;
	import tcw_pkg::*;

	localparam int COLS        = 80;
	localparam int ROWS        = 25;
	localparam int CELLS       = COLS * ROWS;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;
	localparam int RUN_LIMIT   = 20_000_000;

	// same bit order as m_axis_tdata
	typedef struct packed {
		logic              scrolled;
		logic [ATTR_W-1:0] rattr;
		logic [CHAR_W-1:0] rchar;
		logic [POS_W-1:0]  pos;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} console_result_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic [ATTR_W-1:0]   cfg_wdata     = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata  = '0;
	logic                s_axis_tuser  = REQ_WRITE;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;

	// shadow of the console
	logic [CELL_W-1:0] shadow_screen [CELLS];
	int                shadow_col;
	int                shadow_row;
	logic [ATTR_W-1:0] shadow_color;

	console_result_t expected_results [$];
	int              mismatch_count = 0;
	bit              flow_quiet     = 1'b0;
	bit              hold_off_req   = 1'b0;

	text_console_writer #(
		.COLS(COLS),
		.ROWS(ROWS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#(RUN_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	// mostly short idle stretches, a few long ones
	function automatic int idle_len();
		if ($urandom_range(0, 99) < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one request to the shadow and return what the block should report
	function automatic console_result_t predict_console(input logic kind,
			input logic [CHAR_W-1:0] code, input logic [IDX_W-1:0] index);
		console_result_t res;
		int i;
		int pos;
		res = '0;
		if (kind == REQ_WRITE) begin
			if (code != NEWLINE_CODE)
				shadow_screen[shadow_row * COLS + shadow_col] = {shadow_color, code};
			shadow_col++;
			if (shadow_col >= COLS || code == NEWLINE_CODE) begin
				shadow_col = 0;
				shadow_row++;
				// past the bottom: move everything up one row, blank the last
				if (shadow_row >= ROWS) begin
					for (i = 0; i + COLS < CELLS; i++)
						shadow_screen[i] = shadow_screen[i + COLS];
					for (i = CELLS - COLS; i < CELLS; i++)
						shadow_screen[i] = {shadow_color, SPACE_CODE};
					shadow_row   = ROWS - 1;
					res.scrolled = 1'b1;
				end
			end
		end else if (index < CELLS) begin
			{res.rattr, res.rchar} = shadow_screen[index];
		end
		pos     = shadow_row * COLS + shadow_col;
		res.col = shadow_col[COL_W-1:0];
		res.row = shadow_row[ROW_W-1:0];
		res.pos = pos[POS_W-1:0];
		return res;
	endfunction

	// Offer one request from a falling edge until accepted, then maybe idle
	task automatic send_request(input logic kind, input logic [CHAR_W-1:0] code,
			input logic [IDX_W-1:0] index);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {{(S_DATA_W - IDX_W - CHAR_W){1'b0}}, index, code};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_results.push_back(predict_console(kind, code, index));
		@(negedge clk);
		gap = (flow_quiet || $urandom_range(0, 99) < 50) ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic set_text_color(input logic [ATTR_W-1:0] color);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= color;
		@(negedge clk);
		cfg_we       <= 1'b0;
		shadow_color = color;
	endtask

	// Random request mix; reads favor cells right behind the cursor
	task automatic run_console_traffic(input int n_items, input int nl_pct,
			input int rd_pct);
		int k;
		int pos;
		int pick;
		logic [CHAR_W-1:0] code;
		logic [IDX_W-1:0] index;
		for (k = 0; k < n_items; k++) begin
			if (k % 100 == 0)
				flow_quiet = ($urandom_range(0, 3) == 0);
			code  = CHAR_W'($urandom_range(0, 255));
			index = IDX_W'($urandom_range(0, 2047));
			pos   = shadow_row * COLS + shadow_col;
			if ($urandom_range(0, 99) < rd_pct) begin
				pick = $urandom_range(0, 9);
				if (pick < 6 && pos > 0)
					index = IDX_W'(pos - $urandom_range(1, (pos < 4) ? pos : 4));
				else if (pick < 9)
					index = IDX_W'($urandom_range(0, CELLS - 1));
				else
					index = IDX_W'($urandom_range(CELLS, 2047));
				send_request(REQ_READ, code, index);
			end else begin
				if ($urandom_range(0, 99) < nl_pct)
					code = NEWLINE_CODE;
				send_request(REQ_WRITE, code, index);
			end
		end
		flow_quiet = 1'b0;
	endtask

	// Cleared screen, reset color, byte extremes, newlines, reads out of range
	task automatic test_directed();
		send_request(REQ_READ, 8'h00, 11'd0);
		send_request(REQ_READ, 8'hFF, 11'd1999);
		send_request(REQ_READ, 8'h00, 11'd2047);
		send_request(REQ_READ, 8'h00, 11'd2000);
		send_request(REQ_WRITE, 8'h41, 11'd2047);
		send_request(REQ_WRITE, 8'hFF, 11'd0);
		send_request(REQ_WRITE, 8'h00, 11'd1024);
		send_request(REQ_WRITE, NEWLINE_CODE, 11'd0);
		send_request(REQ_WRITE, NEWLINE_CODE, 11'd0);
		send_request(REQ_READ, 8'h00, 11'd0);
		send_request(REQ_READ, 8'h00, 11'd1);
		send_request(REQ_READ, 8'h00, 11'd2);
		send_request(REQ_READ, 8'h00, 11'd80);
		send_request(REQ_WRITE, SPACE_CODE, 11'd0);
		send_request(REQ_READ, 8'h00, 11'd160);
		send_request(REQ_READ, 8'h00, 11'd1024);
	endtask

	// Many short lines so the cursor hits the bottom and scrolls often
	task automatic test_wrap_and_scroll();
		set_text_color(8'hFF);
		run_console_traffic(300, 15, 20);
	endtask

	// Rare newlines: lines wrap at the right edge and scroll by wrapping
	task automatic test_long_lines();
		set_text_color(8'h00);
		run_console_traffic(300, 2, 15);
	endtask

	// Result side holds off while requests keep coming back to back
	task automatic test_backpressure();
		set_text_color(ATTR_W'($urandom_range(0, 255)));
		hold_off_req = 1'b1;
		flow_quiet   = 1'b1;
		run_console_traffic(60, 10, 30);
	endtask

	task automatic test_mixed_traffic();
		set_text_color(ATTR_W'($urandom_range(0, 255)));
		run_console_traffic(290, 8, 30);
		set_text_color(ATTR_W'($urandom_range(0, 255)));
		run_console_traffic(290, 5, 30);
	endtask

	// Result side flow control
	initial begin : result_sink
		int low_run;
		low_run = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else if (low_run > 0) begin
				m_axis_tready <= 1'b0;
				low_run--;
			end else if (!flow_quiet && $urandom_range(0, 99) < 20) begin
				m_axis_tready <= 1'b0;
				low_run = idle_len() - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest pending prediction
	always @(posedge clk) begin : result_check
		console_result_t got;
		console_result_t want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request pending, pos", got.pos, -1);
			end else begin
				want = expected_results.pop_front();
				if (got.col !== want.col)
					report_mismatch("cursor_col", got.col, want.col);
				if (got.row !== want.row)
					report_mismatch("cursor_row", got.row, want.row);
				if (got.pos !== want.pos)
					report_mismatch("cursor_pos", got.pos, want.pos);
				if (got.rchar !== want.rchar)
					report_mismatch("read_char", got.rchar, want.rchar);
				if (got.rattr !== want.rattr)
					report_mismatch("read_attr", got.rattr, want.rattr);
				if (got.scrolled !== want.scrolled)
					report_mismatch("scrolled", got.scrolled, want.scrolled);
			end
		end
	end

	initial begin : test_sequence
		int i;
		int drain;
		console_result_t want;
		for (i = 0; i < CELLS; i++)
			shadow_screen[i] = '0;
		shadow_col   = 0;
		shadow_row   = 0;
		shadow_color = COLOR_RESET;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_wrap_and_scroll();
		test_long_lines();
		test_backpressure();
		test_mixed_traffic();

		// let outstanding results come home, bounded
		s_axis_tvalid <= 1'b0;
		drain = 0;
		while (expected_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		while (expected_results.size() != 0) begin
			want = expected_results.pop_front();
			report_mismatch("result never arrived, pos", -1, want.pos);
		end
		repeat (20) @(negedge clk);

		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
